// ----- rtl/dynamic_synapse_update_defines.svh -----
// assertion helpers shared by the synapse update block
`ifndef DYNAMIC_SYNAPSE_UPDATE_DEFINES_SVH
`define DYNAMIC_SYNAPSE_UPDATE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define DSU_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define DSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/dsu_pkg.sv -----
package dsu_pkg;

  // default sizes
  localparam int NUM_SYNAPSES_DEF   = 4096;
  localparam int EXP_TABLE_SIZE_DEF = 256;

  // port widths
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 30;
  localparam int STEP_W     = 48;
  localparam int IDX_W      = 12;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DELTA_T     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_USE = 2'd1;

  localparam logic [29:0] DELTA_T_RST     = 30'd100000;
  localparam logic [15:0] DEFAULT_USE_RST = 16'd16384;

  // fixed point constants
  localparam logic [15:0] ONE_Q15     = 16'd32768;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
  localparam logic [36:0] ISI_CAP     = 37'd1 << 36;
  localparam logic [63:0] LOG2E_Q48   = 64'h171547652B82F;
  localparam logic [63:0] LN2_Q30     = 64'd744261118;
  localparam logic [63:0] RND_Q45     = 64'd1 << 44;
  localparam logic [63:0] RND_Q30     = 64'd1 << 29;
  localparam int          SERIES_TERMS = 20;
  localparam int          DIV_STEPS    = 48;

  // exponent scale per type, round(log2(e) * 2^48 / tau_ns)
  localparam logic [24:0] C_DEP0 = 25'((LOG2E_Q48 + 64'd72000000) / 64'd144000000);
  localparam logic [24:0] C_DEP1 = 25'((LOG2E_Q48 + 64'd350000000) / 64'd700000000);
  localparam logic [24:0] C_DEP2 = 25'((LOG2E_Q48 + 64'd62500000) / 64'd125000000);
  localparam logic [24:0] C_DEP3 = 25'((LOG2E_Q48 + 64'd550000000) / 64'd1100000000);
  localparam logic [24:0] C_FAC0 = 25'((LOG2E_Q48 + 64'd30000000) / 64'd60000000);
  localparam logic [24:0] C_FAC1 = 25'((LOG2E_Q48 + 64'd10000000) / 64'd20000000);
  localparam logic [24:0] C_FAC2 = 25'((LOG2E_Q48 + 64'd600000000) / 64'd1200000000);
  localparam logic [24:0] C_FAC3 = 25'((LOG2E_Q48 + 64'd25000000) / 64'd50000000);

  localparam logic [24:0] C_DEP [4] = '{C_DEP0, C_DEP1, C_DEP2, C_DEP3};
  localparam logic [24:0] C_FAC [4] = '{C_FAC0, C_FAC1, C_FAC2, C_FAC3};
  localparam logic [15:0] BASE_USE [4] = '{16'd10486, 16'd8192, 16'd1638, 16'd16384};

  typedef enum logic [1:0] {
    CMD_CREATE = 2'd0,
    CMD_RESET  = 2'd1,
    CMD_SPIKE  = 2'd2
  } cmd_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_LOAD, OP_FETCH, OP_DIV_STEP,
    OP_ISI_LO, OP_ISI_HI, OP_Y_LO, OP_Y_HI,
    OP_EXP_IDX, OP_EXP_TAB, OP_EXP_MUL, OP_EXP_SHIFT,
    OP_R_A, OP_R_B, OP_U_A, OP_U_B, OP_INC_A, OP_INC_B, OP_WRITE
  } op_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_FETCH, ST_DIV,
    ST_ISI_LO, ST_ISI_HI, ST_Y_LO, ST_Y_HI,
    ST_EXP_IDX, ST_EXP_TAB, ST_EXP_MUL, ST_EXP_SHIFT,
    ST_R_A, ST_R_B, ST_U_A, ST_U_B, ST_INC_A, ST_INC_B, ST_WRITE
  } state_t;

  // controller to datapath
  typedef struct packed {
    op_t  op;
    logic tsel;   // 0 depression, 1 facilitation
  } dsu_ctl_t;

  // datapath to controller
  typedef struct packed {
    cmd_t cmd;
    logic valid;
    logic spiked;
  } dsu_stat_t;

  // one synapse entry
  typedef struct packed {
    logic [STEP_W-1:0] last_step;
    logic              spiked;
    logic [15:0]       avail_frac;
    logic [15:0]       use_frac;
    logic [1:0]        type_code;
    logic [31:0]       gain;
  } syn_entry_t;

  // signed saturation of a magnitude to 32 bits
  function automatic logic [31:0] sat32(input logic neg, input logic [63:0] mag);
    logic [31:0] res;
    if (neg) begin
      res = (mag >= 64'h8000_0000) ? 32'h8000_0000 : (~mag[31:0]) + 32'd1;
    end else begin
      res = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    end
    return res;
  endfunction

  // 2^-f as exp(-x), x = f*ln2 in Q30, alternating series
  function automatic logic [63:0] pow2_series(input logic [63:0] x);
    logic [63:0] term;
    logic [63:0] sum;
    term = ONE_Q30;
    sum  = ONE_Q30;
    for (int i = 1; i <= SERIES_TERMS; i++) begin
      term = ((term * x) >> 30) / 64'(i);
      if ((i & 1) != 0) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

endpackage

// ----- rtl/dsu_ram.sv -----
module dsu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/dsu_ctrl.sv -----
`include "dynamic_synapse_update_defines.svh"

module dsu_ctrl #(
  parameter int NUM_SYNAPSES = dsu_pkg::NUM_SYNAPSES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  dsu_pkg::dsu_stat_t              stat_i,
  output dsu_pkg::dsu_ctl_t               ctl_o,
  output logic [$clog2(NUM_SYNAPSES)-1:0] clr_addr
);
  import dsu_pkg::*;

  localparam int AW = $clog2(NUM_SYNAPSES);

  state_t          state_r, state_nxt;
  logic [5:0]      cnt_r, cnt_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;
  logic            tsel_r, tsel_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r   <= '0;
      clr_r   <= '0;
      tsel_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      clr_r   <= clr_nxt;
      tsel_r  <= tsel_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    clr_nxt     = clr_r;
    tsel_nxt    = tsel_r;
    ctl_o.op    = OP_NONE;
    ctl_o.tsel  = tsel_r;
    unique case (state_r)
      ST_CLEAR: begin
        ctl_o.op = OP_CLEAR;
        clr_nxt  = clr_r + 1'b1;
        if (clr_r == AW'(NUM_SYNAPSES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          ctl_o.op  = OP_LOAD;
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        ctl_o.op = OP_FETCH;
        cnt_nxt  = '0;
        tsel_nxt = 1'b0;
        if (!stat_i.valid) begin
          state_nxt = ST_WRITE;
        end else begin
          unique case (stat_i.cmd)
            CMD_CREATE: state_nxt = ST_DIV;
            CMD_SPIKE:  state_nxt = stat_i.spiked ? ST_ISI_LO : ST_INC_A;
            default:    state_nxt = ST_WRITE;
          endcase
        end
      end
      ST_DIV: begin
        ctl_o.op = OP_DIV_STEP;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == 6'(DIV_STEPS - 1)) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_ISI_LO: begin
        ctl_o.op  = OP_ISI_LO;
        state_nxt = ST_ISI_HI;
      end
      ST_ISI_HI: begin
        ctl_o.op  = OP_ISI_HI;
        state_nxt = ST_Y_LO;
      end
      ST_Y_LO: begin
        ctl_o.op  = OP_Y_LO;
        state_nxt = ST_Y_HI;
      end
      ST_Y_HI: begin
        ctl_o.op  = OP_Y_HI;
        state_nxt = ST_EXP_IDX;
      end
      ST_EXP_IDX: begin
        ctl_o.op  = OP_EXP_IDX;
        state_nxt = ST_EXP_TAB;
      end
      ST_EXP_TAB: begin
        ctl_o.op  = OP_EXP_TAB;
        state_nxt = ST_EXP_MUL;
      end
      ST_EXP_MUL: begin
        ctl_o.op  = OP_EXP_MUL;
        state_nxt = ST_EXP_SHIFT;
      end
      // depression factor first, then facilitation
      ST_EXP_SHIFT: begin
        ctl_o.op = OP_EXP_SHIFT;
        tsel_nxt = !tsel_r;
        state_nxt = tsel_r ? ST_R_A : ST_Y_LO;
      end
      ST_R_A: begin
        ctl_o.op  = OP_R_A;
        state_nxt = ST_R_B;
      end
      ST_R_B: begin
        ctl_o.op  = OP_R_B;
        state_nxt = ST_U_A;
      end
      ST_U_A: begin
        ctl_o.op  = OP_U_A;
        state_nxt = ST_U_B;
      end
      ST_U_B: begin
        ctl_o.op  = OP_U_B;
        state_nxt = ST_INC_A;
      end
      ST_INC_A: begin
        ctl_o.op  = OP_INC_A;
        state_nxt = ST_INC_B;
      end
      ST_INC_B: begin
        ctl_o.op  = OP_INC_B;
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        ctl_o.op  = OP_WRITE;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy     = (state_r != ST_IDLE);
  assign clr_addr = clr_r;

  `DSU_ASSERT_NEXT(a_accept_fetch, (state_r == ST_IDLE) && start, state_r == ST_FETCH, "request not taken")
  `DSU_ASSERT_SAME(a_div_count, state_r == ST_DIV, cnt_r < 6'(DIV_STEPS), "divider overrun")
  `DSU_ASSERT_NEXT(a_write_idle, state_r == ST_WRITE, state_r == ST_IDLE, "no return to idle")

endmodule

// ----- rtl/dsu_datapath.sv -----
`include "dynamic_synapse_update_defines.svh"

module dsu_datapath #(
  parameter int NUM_SYNAPSES   = dsu_pkg::NUM_SYNAPSES_DEF,
  parameter int EXP_TABLE_SIZE = dsu_pkg::EXP_TABLE_SIZE_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  dsu_pkg::dsu_ctl_t                ctl_i,
  output dsu_pkg::dsu_stat_t               stat_o,
  input  logic [$clog2(NUM_SYNAPSES)-1:0]  clr_addr,
  input  logic [1:0]                       in_command,
  input  logic [dsu_pkg::IDX_W-1:0]        in_synapse_index,
  input  logic [1:0]                       in_syn_type,
  input  logic signed [31:0]               in_weight,
  input  logic [16:0]                      in_decay,
  input  logic [dsu_pkg::STEP_W-1:0]       in_sim_step,
  input  logic                             cfg_we,
  input  logic [dsu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dsu_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                             out_valid,
  output logic signed [31:0]               out_psr_increment,
  output logic [15:0]                      out_use_fraction,
  output logic [15:0]                      out_available_fraction
);
  import dsu_pkg::*;

  localparam int AW  = $clog2(NUM_SYNAPSES);
  localparam int IXW = $clog2(EXP_TABLE_SIZE + 1);
  localparam int EW  = $bits(syn_entry_t);

  // base-2 table, Q1.30, EXP_TABLE_SIZE+1 points over one octave
  logic [30:0] exp_tab [EXP_TABLE_SIZE+1];
  for (genvar k = 0; k <= EXP_TABLE_SIZE; k++) begin : g_tab
    localparam logic [63:0] XK =
      (64'(k) * LN2_Q30 + 64'(EXP_TABLE_SIZE / 2)) / 64'(EXP_TABLE_SIZE);
    assign exp_tab[k] = 31'(pow2_series(XK));
  end

  // configuration
  logic [29:0] dt_r;
  logic [15:0] def_use_r;
  logic [15:0] def_use_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r      <= DELTA_T_RST;
      def_use_r <= DEFAULT_USE_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_DELTA_T) begin
        dt_r <= cfg_data;
      end
      if (cfg_index == CFG_DEFAULT_USE) begin
        def_use_r <= cfg_data[15:0];
      end
    end
  end

  assign def_use_c = (def_use_r > ONE_Q15) ? ONE_Q15 : def_use_r;

  // request and working registers
  logic [1:0]        cmd_r;
  logic [AW-1:0]     idx_r;
  logic              valid_r;
  logic [1:0]        type_in_r;
  logic [31:0]       w_r;
  logic [16:0]       d_r;
  logic [STEP_W-1:0] step_r;
  syn_entry_t        ent_r;
  logic [STEP_W-1:0] diff_r;
  logic [15:0]       u_r, r_r;
  logic [63:0]       acc_r;
  logic [36:0]       isi_r;
  logic [29:0]       y_r;
  logic [IXW-1:0]    idx_tab_r;
  logic [15:0]       rem_r;
  logic [13:0]       n_r;
  logic [30:0]       e0_r, ediff_r, v_r, exd_r, exf_r;
  logic [31:0]       inc_r;
  logic [47:0]       div_q_r;
  logic [16:0]       div_rem_r;

  // entry memory
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  syn_entry_t        ram_wdata;
  syn_entry_t        ram_rdata;
  logic [EW-1:0]     ram_rbits;

  dsu_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_SYNAPSES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (AW'(in_synapse_index)),
    .rdata (ram_rbits)
  );

  assign ram_rdata = syn_entry_t'(ram_rbits);

  assign stat_o.cmd    = cmd_t'(cmd_r);
  assign stat_o.valid  = valid_r;
  assign stat_o.spiked = ram_rdata.spiked;

  // shared multiplier operand select
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [24:0] c_sel;
  logic [15:0] base_u;
  logic [31:0] gm;
  logic        gneg;

  assign c_sel  = ctl_i.tsel ? C_FAC[ent_r.type_code] : C_DEP[ent_r.type_code];
  assign base_u = BASE_USE[ent_r.type_code];
  assign gneg   = ent_r.gain[31];
  assign gm     = gneg ? (~ent_r.gain) + 32'd1 : ent_r.gain;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctl_i.op)
      OP_ISI_LO: begin
        mul_a = 32'(diff_r[17:0]);
        mul_b = 32'(dt_r);
      end
      OP_ISI_HI: begin
        mul_a = 32'(diff_r[35:18]);
        mul_b = 32'(dt_r);
      end
      OP_Y_LO: begin
        mul_a = 32'(isi_r[18:0]);
        mul_b = 32'(c_sel);
      end
      OP_Y_HI: begin
        mul_a = 32'(isi_r[36:19]);
        mul_b = 32'(c_sel);
      end
      OP_EXP_MUL: begin
        mul_a = 32'(ediff_r);
        mul_b = 32'(rem_r);
      end
      OP_R_A: begin
        mul_a = 32'(r_r);
        mul_b = 32'(17'(ONE_Q15) - 17'(u_r));
      end
      OP_R_B: begin
        mul_a = acc_r[31:0];
        mul_b = 32'(exd_r);
      end
      OP_U_A: begin
        mul_a = 32'(u_r);
        mul_b = 32'(ONE_Q15 - base_u);
      end
      OP_U_B: begin
        mul_a = acc_r[31:0];
        mul_b = 32'(exf_r);
      end
      OP_INC_A: begin
        mul_a = 32'(u_r);
        mul_b = 32'(r_r);
      end
      OP_INC_B: begin
        mul_a = gm;
        mul_b = acc_r[31:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // post-multiply arithmetic
  logic [66:0] isi_sum;
  logic [36:0] isi_nxt;
  logic [63:0] y_sum;
  logic [31:0] t_frac;
  logic [30:0] v_nxt;
  logic [30:0] ex_nxt;
  logic [63:0] r_nxt;
  logic [63:0] nu;
  logic [15:0] u_nxt;
  logic [31:0] inc_nxt;
  logic [17:0] div_trial;
  logic [31:0] wmag;
  logic        wneg;
  logic [31:0] gain_nxt;

  assign isi_sum = 67'(acc_r) + (67'(mul_p) << 18);
  assign isi_nxt = (((diff_r[47:36] != '0) && (dt_r != '0)) || (isi_sum > 67'(ISI_CAP)))
                   ? ISI_CAP : isi_sum[36:0];
  assign y_sum   = acc_r + (mul_p << 19);
  assign t_frac  = 32'(y_r[15:0]) * 32'(EXP_TABLE_SIZE);
  assign v_nxt   = e0_r - 31'((mul_p + 64'd32768) >> 16);
  assign ex_nxt  = (n_r >= 14'd31) ? '0 : (v_r >> n_r[4:0]);
  assign r_nxt   = 64'(ONE_Q15) - ((mul_p + RND_Q45) >> 45);
  assign nu      = 64'(base_u) + ((mul_p + RND_Q45) >> 45);
  assign u_nxt   = (nu > 64'(ONE_Q15)) ? ONE_Q15 : nu[15:0];
  assign inc_nxt = sat32(gneg, (mul_p + RND_Q30) >> 30);

  // one restoring division step
  assign div_trial = {div_rem_r, div_q_r[47]};

  // gain from the quotient, zero decay saturates by sign
  assign wneg = w_r[31];
  assign wmag = wneg ? (~w_r) + 32'd1 : w_r;
  always_comb begin
    if (d_r == '0) begin
      gain_nxt = (wmag == '0) ? '0 : sat32(wneg, 64'h1_0000_0000);
    end else begin
      gain_nxt = sat32(wneg, 64'(div_q_r));
    end
  end

  // entry written back
  syn_entry_t wr_ent;
  always_comb begin
    wr_ent = ent_r;
    unique case (cmd_r)
      CMD_CREATE: begin
        wr_ent.type_code  = type_in_r;
        wr_ent.gain       = gain_nxt;
        wr_ent.spiked     = 1'b0;
        wr_ent.use_frac   = def_use_c;
        wr_ent.avail_frac = ONE_Q15;
      end
      CMD_RESET: begin
        wr_ent.spiked     = 1'b0;
        wr_ent.use_frac   = def_use_c;
        wr_ent.avail_frac = ONE_Q15;
      end
      CMD_SPIKE: begin
        wr_ent.last_step  = step_r;
        wr_ent.spiked     = 1'b1;
        wr_ent.use_frac   = u_r;
        wr_ent.avail_frac = r_r;
      end
      default: wr_ent = ent_r;
    endcase
  end

  // memory write port
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = wr_ent;
    if (ctl_i.op == OP_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if ((ctl_i.op == OP_WRITE) && valid_r) begin
      ram_we = 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (ctl_i.op)
      OP_LOAD: begin
        cmd_r     <= in_command;
        idx_r     <= AW'(in_synapse_index);
        valid_r   <= (32'(in_synapse_index) < 32'(NUM_SYNAPSES)) &&
                     ((in_command == CMD_CREATE) || (in_command == CMD_RESET) ||
                      (in_command == CMD_SPIKE));
        type_in_r <= in_syn_type;
        w_r       <= in_weight;
        d_r       <= in_decay;
        step_r    <= in_sim_step;
      end
      OP_FETCH: begin
        ent_r     <= ram_rdata;
        u_r       <= ram_rdata.use_frac;
        r_r       <= ram_rdata.avail_frac;
        diff_r    <= step_r - ram_rdata.last_step;
        div_q_r   <= (48'(wmag) << 16) + 48'(d_r >> 1);
        div_rem_r <= '0;
        inc_r     <= '0;
      end
      OP_DIV_STEP: begin
        if (div_trial >= {1'b0, d_r}) begin
          div_rem_r <= 17'(div_trial - {1'b0, d_r});
          div_q_r   <= {div_q_r[46:0], 1'b1};
        end else begin
          div_rem_r <= div_trial[16:0];
          div_q_r   <= {div_q_r[46:0], 1'b0};
        end
      end
      OP_ISI_LO:  acc_r <= mul_p;
      OP_ISI_HI:  isi_r <= isi_nxt;
      OP_Y_LO:    acc_r <= mul_p;
      OP_Y_HI:    y_r   <= y_sum[61:32];
      OP_EXP_IDX: begin
        idx_tab_r <= IXW'(t_frac >> 16);
        rem_r     <= t_frac[15:0];
        n_r       <= y_r[29:16];
      end
      OP_EXP_TAB: begin
        e0_r    <= exp_tab[idx_tab_r];
        ediff_r <= exp_tab[idx_tab_r] - exp_tab[IXW'(idx_tab_r + 1'b1)];
      end
      OP_EXP_MUL: v_r <= v_nxt;
      OP_EXP_SHIFT: begin
        if (ctl_i.tsel) begin
          exf_r <= ex_nxt;
        end else begin
          exd_r <= ex_nxt;
        end
      end
      OP_R_A:   acc_r <= ONE_Q30 - mul_p;
      OP_R_B:   r_r   <= r_nxt[15:0];
      OP_U_A:   acc_r <= mul_p;
      OP_U_B:   u_r   <= u_nxt;
      OP_INC_A: acc_r <= mul_p;
      OP_INC_B: inc_r <= inc_nxt;
      default: begin
      end
    endcase
  end

  // result registers, one-cycle strobe
  logic        out_valid_r;
  logic [31:0] out_inc_r;
  logic [15:0] out_use_r, out_avail_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (ctl_i.op == OP_WRITE);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.op == OP_WRITE) begin
      if (valid_r) begin
        out_inc_r   <= (cmd_r == CMD_SPIKE) ? inc_r : '0;
        out_use_r   <= wr_ent.use_frac;
        out_avail_r <= wr_ent.avail_frac;
      end else begin
        out_inc_r   <= '0;
        out_use_r   <= '0;
        out_avail_r <= '0;
      end
    end
  end

  assign out_valid              = out_valid_r;
  assign out_psr_increment      = out_inc_r;
  assign out_use_fraction       = out_use_r;
  assign out_available_fraction = out_avail_r;

  `DSU_ASSERT_NEXT(a_strobe_pulse, out_valid_r, !out_valid_r, "result strobe held")
  `DSU_ASSERT_SAME(a_no_bad_write, (ctl_i.op == OP_WRITE) && !valid_r, !ram_we, "ignored request written")
  `DSU_ASSERT_NEXT(a_r_range, ctl_i.op == OP_R_B, r_r <= ONE_Q15, "r above one")

endmodule

// ----- rtl/dynamic_synapse_update.sv -----
// Short-term-plasticity synapse table (depression and facilitation per entry).
// Requests: start with in_command, in_synapse_index and the create or spike
// fields; a request is taken on a clock edge where start is high and busy low.
// Results: out_valid is high for one cycle with out_psr_increment,
// out_use_fraction and out_available_fraction; the receiver cannot stall, and
// busy drops in the cycle the result is shown, so a new request can be taken.
// Configuration: cfg_we, cfg_index, cfg_data write delta_t (0) or default_use
// (1); write only while busy is low.
// One request at a time: a reset command or an ignored request goes from fetch
// straight to write; a first spike of an entry computes only the increment; a
// spike with history adds two exp evaluations on one multiplier; create runs
// the 48-step restoring gain divider. After reset the entry memory is
// cleared, one entry a cycle, and busy stays high until every entry is
// cleared, so no request is taken before then.
module dynamic_synapse_update #(
  parameter int NUM_SYNAPSES   = dsu_pkg::NUM_SYNAPSES_DEF,
  parameter int EXP_TABLE_SIZE = dsu_pkg::EXP_TABLE_SIZE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_command,
  input  logic [dsu_pkg::IDX_W-1:0]      in_synapse_index,
  input  logic [1:0]                     in_syn_type,
  input  logic signed [31:0]             in_weight,
  input  logic [16:0]                    in_decay,
  input  logic [dsu_pkg::STEP_W-1:0]     in_sim_step,
  input  logic                           cfg_we,
  input  logic [dsu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dsu_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           out_valid,
  output logic signed [31:0]             out_psr_increment,
  output logic [15:0]                    out_use_fraction,
  output logic [15:0]                    out_available_fraction
);
  import dsu_pkg::*;

  localparam int AW = $clog2(NUM_SYNAPSES);

  dsu_ctl_t      ctl;
  dsu_stat_t     stat;
  logic [AW-1:0] clr_addr;

  // sequencer
  dsu_ctrl #(
    .NUM_SYNAPSES (NUM_SYNAPSES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .stat_i   (stat),
    .ctl_o    (ctl),
    .clr_addr (clr_addr)
  );

  // arithmetic, entry memory and configuration
  dsu_datapath #(
    .NUM_SYNAPSES   (NUM_SYNAPSES),
    .EXP_TABLE_SIZE (EXP_TABLE_SIZE)
  ) u_datapath (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .ctl_i                  (ctl),
    .stat_o                 (stat),
    .clr_addr               (clr_addr),
    .in_command             (in_command),
    .in_synapse_index       (in_synapse_index),
    .in_syn_type            (in_syn_type),
    .in_weight              (in_weight),
    .in_decay               (in_decay),
    .in_sim_step            (in_sim_step),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .out_valid              (out_valid),
    .out_psr_increment      (out_psr_increment),
    .out_use_fraction       (out_use_fraction),
    .out_available_fraction (out_available_fraction)
  );

endmodule

// ----- verif/dsu_checker.sv -----
module dsu_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  logic [1:0]                     in_command,
  input  logic [dsu_pkg::IDX_W-1:0]      in_synapse_index,
  input  logic [1:0]                     in_syn_type,
  input  logic signed [31:0]             in_weight,
  input  logic [16:0]                    in_decay,
  input  logic [dsu_pkg::STEP_W-1:0]     in_sim_step,
  input  logic                           cfg_we,
  input  logic [dsu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dsu_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           out_valid,
  input  logic signed [31:0]             out_psr_increment,
  input  logic [15:0]                    out_use_fraction,
  input  logic [15:0]                    out_available_fraction,
  output int                             error_count,
  output int                             pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import dsu_pkg::*;

  localparam int TABLE_N = 4096;
  localparam int POW2_N  = 256;
  localparam logic [63:0] STEP_MASK = 64'hFFFF_FFFF_FFFF;
  localparam logic [63:0] ISI_MAX   = 64'd1 << 36;
  localparam logic [63:0] LN2_SCALED = 64'd744261118;
  localparam logic [63:0] LOG2E_SCALED = 64'h171547652B82F;

  typedef struct packed {
    logic signed [31:0] increment;
    logic [15:0]        use_q;
    logic [15:0]        avail_q;
  } syn_result_t;

  // time constants in ns per type
  localparam logic [63:0] TAU_DEP_NS [4] = '{64'd144000000, 64'd700000000,
                                             64'd125000000, 64'd1100000000};
  localparam logic [63:0] TAU_FAC_NS [4] = '{64'd60000000, 64'd20000000,
                                             64'd1200000000, 64'd50000000};
  localparam logic [15:0] U_BASE [4] = '{16'd10486, 16'd8192, 16'd1638, 16'd16384};

  syn_result_t   expected_q[$];
  longint        pow2_lut [POW2_N+1];
  logic [47:0]   last_step_m [TABLE_N];
  bit            spiked_m    [TABLE_N];
  logic [15:0]   avail_m     [TABLE_N];
  logic [15:0]   use_m       [TABLE_N];
  logic [1:0]    type_m      [TABLE_N];
  logic [31:0]   gain_m      [TABLE_N];
  logic [29:0]   step_ns;
  logic [15:0]   init_use;

  // 2^-f table, Q1.30, alternating series of exp(-f ln2)
  initial begin
    logic [63:0] x, term;
    longint      acc;
    error_count = 0;
    pending_count = 0;
    for (int k = 0; k <= POW2_N; k++) begin
      x = (64'(k) * LN2_SCALED + POW2_N / 2) / POW2_N;
      term = 64'd1 << 30;
      acc = longint'(64'd1 << 30);
      for (int i = 1; i <= 20; i++) begin
        term = ((term * x) >> 30) / 64'(i);
        if (i % 2 == 1) acc = acc - longint'(term);
        else acc = acc + longint'(term);
      end
      pow2_lut[k] = acc;
    end
  end

  function automatic logic [31:0] clip32(input bit neg, input logic [63:0] mag);
    if (neg) return (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-mag);
    return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
  endfunction

  // exp(-isi/tau) in Q1.30
  function automatic logic [63:0] decay_factor(input logic [63:0] isi, input logic [63:0] tau);
    logic [63:0] scale, y, ipart, t, idx, rem;
    longint      v;
    scale = (LOG2E_SCALED + tau / 2) / tau;
    y = (isi * scale) >> 32;
    ipart = y >> 16;
    if (ipart >= 31) return 64'd0;
    t = (y & 64'hFFFF) * POW2_N;
    idx = t >> 16;
    rem = t & 64'hFFFF;
    v = pow2_lut[idx] - (((pow2_lut[idx] - pow2_lut[idx+1]) * longint'(rem) + 32768) >>> 16);
    if (v < 0) v = 0;
    return 64'(v) >> ipart;
  endfunction

  function automatic void restore_entry(input int i);
    use_m[i] = (init_use > ONE_Q15) ? ONE_Q15 : init_use;
    avail_m[i] = ONE_Q15;
    spiked_m[i] = 0;
  endfunction

  // next state of the addressed entry and the result it yields
  function automatic syn_result_t apply_request(input logic [1:0] cmd, input int i,
      input logic [1:0] typ, input logic [31:0] w, input logic [16:0] d,
      input logic [47:0] stp);
    syn_result_t res;
    logic [63:0] mag, u, r, gm, diff, isi, ed, ef, m, nu;
    bit          neg;
    int          t;
    res = '0;
    if (i >= TABLE_N || !(cmd inside {CMD_CREATE, CMD_RESET, CMD_SPIKE})) return res;
    if (cmd == CMD_CREATE) begin
      neg = w[31];
      mag = neg ? (64'h1_0000_0000 - 64'(w)) : 64'(w);
      type_m[i] = typ;
      if (d == 0) gain_m[i] = (mag == 0) ? 32'd0 : clip32(neg, 64'h1_0000_0000);
      else gain_m[i] = clip32(neg, ((mag << 16) + 64'(d) / 2) / 64'(d));
      restore_entry(i);
    end else if (cmd == CMD_RESET) begin
      restore_entry(i);
    end else begin
      t = type_m[i];
      u = use_m[i];
      r = avail_m[i];
      neg = gain_m[i][31];
      gm = neg ? (64'h1_0000_0000 - 64'(gain_m[i])) : 64'(gain_m[i]);
      if (spiked_m[i]) begin
        diff = (64'(stp) - 64'(last_step_m[i])) & STEP_MASK;
        if (step_ns != 0 && diff > ISI_MAX / 64'(step_ns)) isi = ISI_MAX;
        else isi = diff * 64'(step_ns);
        if (isi > ISI_MAX) isi = ISI_MAX;
        ed = decay_factor(isi, TAU_DEP_NS[t]);
        ef = decay_factor(isi, TAU_FAC_NS[t]);
        // r and u relax from their old values
        m = (64'd1 << 30) - r * (64'(ONE_Q15) - u);
        r = 64'(ONE_Q15) - ((m * ed + (64'd1 << 44)) >> 45);
        nu = 64'(U_BASE[t])
           + ((u * (64'(ONE_Q15) - 64'(U_BASE[t])) * ef + (64'd1 << 44)) >> 45);
        u = (nu > ONE_Q15) ? 64'(ONE_Q15) : nu;
        use_m[i] = u[15:0];
        avail_m[i] = r[15:0];
      end
      res.increment = clip32(neg, ((gm * u) * r + (64'd1 << 29)) >> 30);
      last_step_m[i] = stp;
      spiked_m[i] = 1;
    end
    res.use_q = use_m[i];
    res.avail_q = avail_m[i];
    return res;
  endfunction

  // compare results, then record new requests and register writes
  always @(posedge clk) begin
    syn_result_t got, want;
    if (!rst_n) begin
      step_ns <= DELTA_T_RST;
      init_use <= DEFAULT_USE_RST;
      for (int i = 0; i < TABLE_N; i++) spiked_m[i] = 0;
      expected_q.delete();
    end else begin
      if (out_valid) begin
        got = '{out_psr_increment, out_use_fraction, out_available_fraction};
        if (expected_q.size() == 0) begin
          $display("%0t: result with none expected: inc %h use %h avail %h",
                   $time, got.increment, got.use_q, got.avail_q);
          error_count++;
        end else begin
          want = expected_q.pop_front();
          if (got.increment !== want.increment) begin
            $display("%0t: psr_increment expected %h actual %h",
                     $time, want.increment, got.increment);
            error_count++;
          end
          if (got.use_q !== want.use_q) begin
            $display("%0t: use_fraction expected %h actual %h",
                     $time, want.use_q, got.use_q);
            error_count++;
          end
          if (got.avail_q !== want.avail_q) begin
            $display("%0t: available_fraction expected %h actual %h",
                     $time, want.avail_q, got.avail_q);
            error_count++;
          end
        end
      end
      if (start && !busy)
        expected_q.push_back(apply_request(in_command, int'(in_synapse_index), in_syn_type,
                                           in_weight, in_decay, in_sim_step));
      if (cfg_we) begin
        if (cfg_index == CFG_DELTA_T) step_ns <= cfg_data;
        else if (cfg_index == CFG_DEFAULT_USE) init_use <= cfg_data[15:0];
      end
    end
    pending_count = expected_q.size();
  end

endmodule

// ----- verif/tb_dynamic_synapse_update.sv -----
module tb_dynamic_synapse_update;
  timeunit 1ns;
  timeprecision 1ps;
  import dsu_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RUN_LIMIT = 1500000;
  localparam int POOL_N = 10;
  localparam int PHASE_N = 6;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic [1:0]  in_command = '0;
  logic [11:0] in_synapse_index = '0;
  logic [1:0]  in_syn_type = '0;
  logic signed [31:0] in_weight = '0;
  logic [16:0] in_decay = '0;
  logic [47:0] in_sim_step = '0;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = '0;
  logic [29:0] cfg_data = '0;
  logic        out_valid;
  logic signed [31:0] out_psr_increment;
  logic [15:0] out_use_fraction;
  logic [15:0] out_available_fraction;
  int          error_count;
  int          pending_count;
  int          cycle_count = 0;

  bit          no_gaps;
  logic [11:0] pool [POOL_N] = '{12'd0, 12'd1, 12'd2, 12'd3, 12'd4, 12'd5,
                                  12'd2047, 12'd2048, 12'd4094, 12'd4095};
  logic [47:0] pool_step [POOL_N];

  always #1 clk = ~clk;

  dynamic_synapse_update dut (.*);

  dsu_checker chk (.*);

  // run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (no_gaps || p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // hold a request until the block takes it
  task automatic send_request(input logic [1:0] cmd, input logic [11:0] idx,
      input logic [1:0] typ, input logic [31:0] w, input logic [16:0] d,
      input logic [47:0] stp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    in_command <= cmd;
    in_synapse_index <= idx;
    in_syn_type <= typ;
    in_weight <= w;
    in_decay <= d;
    in_sim_step <= stp;
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [29:0] val);
    start <= 0;
    forever begin
      @(negedge clk);
      if (pending_count == 0 && !busy) break;
    end
    repeat (4) @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic [31:0] rand_weight();
    logic [31:0] w;
    w = $urandom_range(0, 99) < 40 ? $urandom() : $urandom_range(0, 32'h3FFFF);
    if ($urandom_range(0, 1)) w = -w;
    return w;
  endfunction

  function automatic logic [16:0] rand_decay();
    int p;
    p = $urandom_range(0, 99);
    if (p < 3) return 17'd0;
    if (p < 8) return 17'($urandom_range(65537, 131071));
    return 17'($urandom_range(1, 65536));
  endfunction

  task automatic spike_pool(input int k, input int mode);
    logic [47:0] stp;
    case (mode)
      0: stp = pool_step[k] + $urandom_range(0, 3000);
      1: stp = pool_step[k] + $urandom_range(0, 300000);
      default: stp = {16'($urandom()), 32'($urandom())};
    endcase
    pool_step[k] = stp;
    send_request(CMD_SPIKE, pool[k], 2'($urandom()), $urandom(), 17'($urandom()), stp);
  endtask

  task automatic random_request();
    int p, k;
    logic [11:0] idx;
    p = $urandom_range(0, 99);
    k = $urandom_range(0, POOL_N - 1);
    if (p < 7) begin
      send_request(CMD_CREATE, pool[k], 2'($urandom()), rand_weight(), rand_decay(),
                   {16'($urandom()), 32'($urandom())});
    end else if (p < 12) begin
      idx = 12'($urandom());
      send_request(CMD_CREATE, idx, 2'($urandom()), rand_weight(), rand_decay(), '0);
      if ($urandom_range(0, 1))
        send_request(CMD_SPIKE, idx, '0, '0, '0, {16'($urandom()), 32'($urandom())});
    end else if (p < 18) begin
      send_request(CMD_RESET, pool[k], 2'($urandom()), $urandom(), 17'($urandom()),
                   {16'($urandom()), 32'($urandom())});
    end else if (p < 21) begin
      send_request(CMD_UNUSED, 12'($urandom()), 2'($urandom()), $urandom(),
                   17'($urandom()), {16'($urandom()), 32'($urandom())});
    end else if (p < 80) begin
      spike_pool(k, 0);
    end else if (p < 95) begin
      spike_pool(k, 1);
    end else begin
      spike_pool(k, 2);
    end
  endtask

  initial begin
    logic [29:0] step_set [PHASE_N] = '{30'd100000, 30'd1, 30'd1000000000, 30'd0,
                                         30'h3FFF_FFFF, 30'd250000};
    logic [29:0] use_set [PHASE_N] = '{30'd16384, 30'd0, 30'd32768, 30'hFFFF,
                                        30'h3FFF_0000, 30'd5000};
    no_gaps = 0;
    for (int k = 0; k < POOL_N; k++) pool_step[k] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1;

    // directed: each type, extreme weights and decays
    send_request(CMD_CREATE, pool[0], 2'd0, 32'h7FFF_FFFF, 17'd1, '0);
    send_request(CMD_CREATE, pool[1], 2'd1, 32'h8000_0000, 17'd65536, '0);
    send_request(CMD_CREATE, pool[2], 2'd2, 32'h0000_0000, 17'd0, '0);
    send_request(CMD_CREATE, pool[3], 2'd3, 32'hFFFF_FFFF, 17'h1FFFF, '0);
    send_request(CMD_CREATE, pool[4], 2'd3, 32'h0001_0000, 17'd0, '0);
    send_request(CMD_CREATE, pool[5], 2'd0, 32'hFFF0_0000, 17'd32768, '0);
    send_request(CMD_CREATE, pool[6], 2'd1, 32'h0002_0000, 17'd65536, '0);
    send_request(CMD_CREATE, pool[7], 2'd2, 32'h0003_8000, 17'd40000, '0);
    send_request(CMD_CREATE, pool[8], 2'd0, 32'h0000_8000, 17'd65536, '0);
    send_request(CMD_CREATE, pool[9], 2'd3, 32'h0004_0000, 17'd30000, '0);
    // first spike, then short and long intervals, backwards step, wrap
    for (int k = 0; k < 4; k++) spike_pool(k, 0);
    spike_pool(6, 0);
    spike_pool(6, 0);
    spike_pool(7, 1);
    pool_step[9] = 48'hFFFF_FFFF_FF00;
    spike_pool(9, 0);
    spike_pool(9, 0);
    pool_step[8] = 48'd50;
    spike_pool(8, 0);
    send_request(CMD_SPIKE, pool[8], '0, '0, '0, 48'd10);
    pool_step[8] = 48'd10;
    send_request(CMD_RESET, pool[6], '0, '0, '0, '0);
    spike_pool(6, 0);
    send_request(CMD_UNUSED, 12'hFFF, 2'd3, 32'hFFFF_FFFF, 17'h1FFFF, 48'hFFFF_FFFF_FFFF);

    // random traffic across register settings
    for (int ph = 0; ph < PHASE_N; ph++) begin
      write_reg(CFG_DELTA_T, step_set[ph]);
      write_reg(CFG_DEFAULT_USE, use_set[ph]);
      no_gaps = (ph % 3 == 2);
      for (int n = 0; n < 150; n++) random_request();
    end

    start <= 0;
    forever begin
      @(negedge clk);
      if (pending_count == 0) break;
    end
    repeat (60) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- dynamic_synapse_update.f -----
+incdir+rtl
rtl/dsu_pkg.sv
rtl/dsu_ram.sv
rtl/dsu_ctrl.sv
rtl/dsu_datapath.sv
rtl/dynamic_synapse_update.sv
verif/dsu_checker.sv
verif/tb_dynamic_synapse_update.sv
